>>> src/hsal_pkg.sv
// hsal_pkg: shared types and flag codes for the hall state angle learner
// used by the channel interfaces and the top level; no dependencies
`timescale 1ns / 1ps

package hsal_pkg;

  // single-bit flag carried on the channels
  typedef logic hsal_flag_t;

  // meaning of the record input
  localparam hsal_flag_t REC_CLEAR = 1'b0;
  localparam hsal_flag_t REC_LEARN = 1'b1;

  // meaning of the idle flag on the result word
  localparam hsal_flag_t IDLE_BUSY = 1'b0;
  localparam hsal_flag_t IDLE_OFF  = 1'b1;

endpackage

>>> src/hsal_if.sv
// hsal_if: valid/ready channel interfaces for sample words and result words
// depends on hsal_pkg for the flag type
`timescale 1ns / 1ps

interface hsal_in_if
  import hsal_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int CODE_BITS  = 4
);
  logic                         valid;
  logic                         ready;
  logic [CODE_BITS-1:0]         hall_code;
  hsal_flag_t                   record;
  logic signed [ANGLE_BITS-1:0] ref_angle;

  modport source (output valid, hall_code, record, ref_angle, input ready);
  modport sink   (input valid, hall_code, record, ref_angle, output ready);
endinterface

interface hsal_out_if
  import hsal_pkg::*;
#(
  parameter int ANGLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] position;
  hsal_flag_t                   idle_flag;
  hsal_flag_t                   code_parity;

  modport source (output valid, position, idle_flag, code_parity, input ready);
  modport sink   (input valid, position, idle_flag, code_parity, output ready);
endinterface

>>> src/hall_state_angle_learner.sv
// hall_state_angle_learner: learns one rotor angle per hall code from a reference angle
// depends on hsal_pkg and the channel interfaces in hsal_if
`timescale 1ns / 1ps
//
// Usage
//   in_ch  (sink):   one sample word per transfer: hall_code, record, ref_angle.
//   out_ch (source): one result word per sample: position, idle_flag, code_parity.
//   A word moves at a rising clk edge where valid and ready are both high.
//   While record is high the block widens the wrapped min/max angle of the
//   current code and stores min + half span as that code's position. A word
//   with record low forgets all min/max bounds; learned positions stay.
// Timing
//   Three-stage pipeline around the bound and position memories: bound read,
//   bound update and write-back, span/position update and output register.
//   An accepted word passes the stage 1, stage 2 and output registers to out_ch.
//   One word per cycle sustained while out_ch.ready is high; the bound memory
//   read-modify-write loop closes through a forwarding path from the next stage.
// Reset and stall
//   rst_n (synchronous, active low) empties the pipeline, clears all bound
//   valid flags and makes every learned position read as zero.
//   A stalled receiver freezes the whole pipeline; in_ch.ready follows
//   out_ch.ready while the output register is full.

module hall_state_angle_learner
  import hsal_pkg::*;
#(
  parameter int ANGLE_BITS = 16,
  parameter int CODE_BITS  = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  hsal_in_if.sink     in_ch,
  hsal_out_if.source  out_ch
);

  localparam int ENTRIES = 1 << CODE_BITS;
  localparam int AMSB    = ANGLE_BITS - 1;

  typedef logic [ANGLE_BITS-1:0] ang_t;
  typedef logic [CODE_BITS-1:0]  code_t;

  // memories
  ang_t lo_mem  [ENTRIES];
  ang_t hi_mem  [ENTRIES];
  ang_t pos_mem [ENTRIES];

  logic [ENTRIES-1:0] bnd_vld_r;
  logic [ENTRIES-1:0] pos_vld_r;

  // stage 1: bound read data
  logic       s1_vld_r;
  code_t      s1_code_r;
  hsal_flag_t s1_rec_r;
  hsal_flag_t s1_par_r;
  ang_t       s1_ang_r;
  ang_t       lo_rd_r;
  ang_t       hi_rd_r;

  // stage 2: updated bounds, position read data
  logic       s2_vld_r;
  code_t      s2_code_r;
  hsal_flag_t s2_rec_r;
  hsal_flag_t s2_par_r;
  ang_t       s2_lo_r;
  ang_t       s2_hi_r;
  ang_t       s2_lo_nxt;
  ang_t       s2_hi_nxt;
  ang_t       pos_rd_r;

  // output register
  logic       out_vld_r;
  code_t      out_code_r;
  hsal_flag_t out_rec_r;
  hsal_flag_t out_par_r;
  ang_t       out_pos_r;
  ang_t       out_pos_nxt;

  logic adv;
  logic bnd_fwd;
  logic pos_fwd;
  logic first_hit;
  ang_t lo_cur;
  ang_t hi_cur;
  ang_t d_lo;
  ang_t d_hi;
  ang_t span;
  ang_t half;
  ang_t pos_calc;
  ang_t pos_stored;

  // pipeline moves whenever the output register can take a word
  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: forward bounds written by the word one stage ahead
  assign bnd_fwd   = s2_vld_r && (s2_rec_r == REC_LEARN) && (s2_code_r == s1_code_r);
  assign lo_cur    = bnd_fwd ? s2_lo_r : lo_rd_r;
  assign hi_cur    = bnd_fwd ? s2_hi_r : hi_rd_r;
  assign first_hit = !bnd_vld_r[s1_code_r];
  assign d_lo      = s1_ang_r - lo_cur;
  assign d_hi      = s1_ang_r - hi_cur;

  // widen the wrapped bounds, or seed both on the first sample
  always_comb begin
    s2_lo_nxt = lo_cur;
    s2_hi_nxt = hi_cur;
    if (first_hit || d_lo[AMSB]) begin
      s2_lo_nxt = s1_ang_r;
    end
    if (first_hit || ((d_hi != '0) && !d_hi[AMSB])) begin
      s2_hi_nxt = s1_ang_r;
    end
  end

  // stage 2: midpoint of the wrapped span, arithmetic half
  assign span     = s2_hi_r - s2_lo_r;
  assign half     = {span[AMSB], span[AMSB:1]};
  assign pos_calc = s2_lo_r + half;

  // stored position, forwarded from the word in the output register
  assign pos_fwd    = out_vld_r && (out_rec_r == REC_LEARN) && (out_code_r == s2_code_r);
  assign pos_stored = pos_fwd ? out_pos_r : (pos_vld_r[s2_code_r] ? pos_rd_r : '0);
  assign out_pos_nxt = (s2_rec_r == REC_LEARN) ? pos_calc : pos_stored;

  // bound memories: read on accept, write back from stage 1
  always_ff @(posedge clk) begin
    if (adv) begin
      lo_rd_r <= lo_mem[in_ch.hall_code];
      hi_rd_r <= hi_mem[in_ch.hall_code];
      if (s1_vld_r && (s1_rec_r == REC_LEARN)) begin
        lo_mem[s1_code_r] <= s2_lo_nxt;
        hi_mem[s1_code_r] <= s2_hi_nxt;
      end
    end
  end

  // position memory: read entering stage 2, write from stage 2
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_rd_r <= pos_mem[s1_code_r];
      if (s2_vld_r && (s2_rec_r == REC_LEARN)) begin
        pos_mem[s2_code_r] <= pos_calc;
      end
    end
  end

  // payload pipeline registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_code_r  <= in_ch.hall_code;
      s1_rec_r   <= in_ch.record;
      s1_par_r   <= ^in_ch.hall_code;
      s1_ang_r   <= in_ch.ref_angle;
      s2_code_r  <= s1_code_r;
      s2_rec_r   <= s1_rec_r;
      s2_par_r   <= s1_par_r;
      s2_lo_r    <= s2_lo_nxt;
      s2_hi_r    <= s2_hi_nxt;
      out_code_r <= s2_code_r;
      out_rec_r  <= s2_rec_r;
      out_par_r  <= s2_par_r;
      out_pos_r  <= out_pos_nxt;
    end
  end

  // control: stage valids and entry valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      bnd_vld_r <= '0;
      pos_vld_r <= '0;
    end else if (adv) begin
      s1_vld_r  <= in_ch.valid;
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
      if (s1_vld_r) begin
        if (s1_rec_r == REC_LEARN) begin
          bnd_vld_r[s1_code_r] <= 1'b1;
        end else begin
          bnd_vld_r <= '0;
        end
      end
      if (s2_vld_r && (s2_rec_r == REC_LEARN)) begin
        pos_vld_r[s2_code_r] <= 1'b1;
      end
    end
  end

  // result word
  assign out_ch.valid       = out_vld_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.idle_flag   = (out_rec_r == REC_LEARN) ? IDLE_BUSY : IDLE_OFF;
  assign out_ch.code_parity = out_par_r;

`ifndef SYNTHESIS
  // a clearing word wipes every bound valid flag
  a_clear_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_vld_r && (s1_rec_r == REC_CLEAR) |=> bnd_vld_r == '0)
    else $error("bound valid flags not cleared");

  // a learning word leaves its entry valid
  a_set_bound: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_vld_r && (s1_rec_r == REC_LEARN) |=> bnd_vld_r[$past(s1_code_r)])
    else $error("bound valid flag not set");

  // learned positions are never forgotten
  a_pos_kept: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (pos_vld_r & $past(pos_vld_r)) == $past(pos_vld_r))
    else $error("position valid flag dropped");
`endif

endmodule
